// ===== design/cmt_pkg.sv =====
// Shared types and constants for the Carmichael number test unit.
// No dependencies; cmt_divider, the test unit and the testbench use this package.
package cmt_pkg;

  // Divider operand width and divisor counter width
  localparam int DIV_W = 32;
  localparam int I_W   = 16;

  // Trial division starts at the smallest prime
  localparam logic [DIV_W-1:0] FIRST_DIVISOR = 32'd2;

  // Request from the sequencer to the shared divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // Response from the shared divider
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== design/cmt_in_if.sv =====
// Input channel of the Carmichael number test unit: valid, ready, value.
// Depends on nothing.
interface cmt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

// ===== design/cmt_out_if.sv =====
// Result channel of the Carmichael number test unit: valid, ready, flag.
// Depends on nothing.
interface cmt_out_if;
  logic valid;
  logic ready;
  logic flag;

  modport source (output valid, output flag, input ready);
  modport sink (input valid, input flag, output ready);
endinterface

// ===== design/cmt_divider.sv =====
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on cmt_pkg for the request and response structs.
module cmt_divider import cmt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
  end

  // Count steps and flag the finished quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load operands, then restore or keep the partial remainder each step
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[DIV_W]) begin
        rem <= diff[DIV_W-1:0];
      end else begin
        rem <= trial[DIV_W-1:0];
      end
      quo <= {quo[DIV_W-2:0], ~diff[DIV_W]};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while still busy");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < dvs))
    else $error("divider remainder not below divisor");

endmodule

// ===== design/carmichael_number_test_unit.sv =====
// Carmichael number test unit: one signed 32-bit word in, one flag word out.
// Each word is tested by Korselt's criterion with trial division on a single
// shared 32-step divider. Each divide runs through the start request, the
// operand load, 32 quotient steps and the cycle that sees done. Primes near
// 2^31, and other values with no factor below about 46341, take the longest.
// Negative values, 0 and 1 skip the divider. The input is ready only while
// no item is in progress; a finished flag waits in the output register until
// taken.
// Depends on cmt_pkg, cmt_in_if, cmt_out_if and cmt_divider.
module carmichael_number_test_unit import cmt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cmt_in_if.sink    item,
  cmt_out_if.source result
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIVK   = 6'b000010,
    S_DIVQ   = 6'b000100,
    S_DIVN   = 6'b001000,
    S_DIVE   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t           state;
  logic [DIV_W-1:0] n;
  logic [DIV_W-1:0] nm1;
  logic [DIV_W-1:0] k;
  logic [I_W-1:0]   i;
  logic             res;
  logic             out_valid;
  logic             out_bit;
  div_req_t         req;
  div_rsp_t         rsp;
  logic             accept;
  logic [DIV_W-1:0] raw;
  logic [DIV_W-1:0] i_ext;
  logic [DIV_W-1:0] i_inc;
  logic             start_next;
  logic             load_out;

  cmt_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign raw        = DIV_W'(item.value);
  assign i_ext      = DIV_W'(i);
  assign i_inc      = DIV_W'(i) + DIV_W'(1);
  assign load_out   = (state == S_RESULT) && (!out_valid || result.ready);

  assign result.valid = out_valid;
  assign result.flag  = out_bit;

  // Decide whether the sequencer issues a divide at this edge
  always_comb begin
    start_next = 1'b0;
    unique case (state)
      S_IDLE: start_next = accept && !raw[DIV_W-1] && (raw >= FIRST_DIVISOR);
      S_DIVK: start_next = rsp.done && !((i_ext > rsp.quot) && (k == n));
      S_DIVQ: start_next = rsp.done && (rsp.rem != '0);
      S_DIVN: start_next = rsp.done && (rsp.rem == '0);
      default: start_next = 1'b0;
    endcase
  end

  // Sequence the trial division over the shared divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req.start <= 1'b0;
    end else begin
      req.start <= start_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n   <= raw;
            nm1 <= raw - DIV_W'(1);
            k   <= raw;
            i   <= I_W'(FIRST_DIVISOR);
            if (raw[DIV_W-1] || raw < FIRST_DIVISOR) begin
              res   <= 1'b0;
              state <= S_RESULT;
            end else begin
              req.dividend <= raw;
              req.divisor  <= FIRST_DIVISOR;
              state        <= S_DIVK;
            end
          end
        end
        S_DIVK: begin
          if (rsp.done) begin
            priority if (i_ext > rsp.quot) begin
              // Walk ended: k is the last prime factor
              if (k == n) begin
                res   <= 1'b0;
                state <= S_RESULT;
              end else begin
                req.dividend <= nm1;
                req.divisor  <= k - DIV_W'(1);
                state        <= S_DIVE;
              end
            end else if (rsp.rem == '0) begin
              // Factor found: drop it from k, then check its square
              k            <= rsp.quot;
              req.dividend <= rsp.quot;
              req.divisor  <= i_ext;
              state        <= S_DIVQ;
            end else begin
              // Advance to the next candidate
              i            <= i + 1'b1;
              req.dividend <= k;
              req.divisor  <= i_inc;
            end
          end
        end
        S_DIVQ: begin
          if (rsp.done) begin
            if (rsp.rem == '0) begin
              res   <= 1'b0;
              state <= S_RESULT;
            end else begin
              req.dividend <= nm1;
              req.divisor  <= i_ext - DIV_W'(1);
              state        <= S_DIVN;
            end
          end
        end
        S_DIVN: begin
          if (rsp.done) begin
            if (rsp.rem != '0) begin
              res   <= 1'b0;
              state <= S_RESULT;
            end else begin
              req.dividend <= k;
              req.divisor  <= i_ext;
              state        <= S_DIVK;
            end
          end
        end
        S_DIVE: begin
          if (rsp.done) begin
            res   <= (rsp.rem == '0);
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          // Hold until the output register is free
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Load a finished flag, or drop the word once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
      out_bit   <= res;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  a_neg_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && item.value[31]) |=> (state == S_RESULT && !res))
    else $error("negative word not rejected at once");

  a_done_waiting: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_DIVK || state == S_DIVQ || state == S_DIVN ||
                  state == S_DIVE))
    else $error("divider result arrived with no divide pending");

  a_divisor_min: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVK || state == S_DIVQ || state == S_DIVN) |-> (i >= I_W'(2)))
    else $error("trial divisor below two");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for carmichael_number_test_unit (Korselt criterion).
// Drives signed 32-bit words and checks each returned flag against a local
// predictor. Depends on cmt_pkg, cmt_in_if, cmt_out_if and the unit itself.

// Holds the flags still owed by the unit, oldest first
class flag_scoreboard;
  bit flag_q[$];
  int mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Korselt test by trial division, continuing from the last divisor found
  function bit korselt_flag(logic [31:0] raw);
    bit [31:0] k;
    bit [31:0] i;
    bit [31:0] nm1;
    if (raw[31] || raw < cmt_pkg::FIRST_DIVISOR) return 1'b0;
    k = raw;
    i = cmt_pkg::FIRST_DIVISOR;
    nm1 = raw - 32'd1;
    while (i <= k / i) begin
      if (k % i == 32'd0) begin
        if ((k / i) % i == 32'd0) return 1'b0;
        if (nm1 % (i - 32'd1) != 32'd0) return 1'b0;
        k = k / i;
      end else begin
        i++;
      end
    end
    return (k != raw) && (nm1 % (k - 32'd1) == 32'd0);
  endfunction

  // Queue the expected flag for an accepted word
  function void note_value(logic [31:0] value);
    flag_q.push_back(korselt_flag(value));
  endfunction

  // Compare a returned flag with the oldest expected one
  function void check_flag(logic flag);
    bit want;
    if (flag_q.size() == 0) begin
      $error("flag: unexpected word, expected none, actual %0b", flag);
      mismatches++;
    end else begin
      want = flag_q.pop_front();
      if (flag !== want) begin
        $error("flag mismatch: expected %0b, actual %0b", want, flag);
        mismatches++;
      end
    end
  endfunction
endclass

module testbench;

  localparam int RANDOM_WORDS = 100;
  localparam int DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  // Extremes, small cases, primes, squares and known Carmichael numbers
  localparam logic signed [31:0] DIRECTED_VALUES [23] = '{
    32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd6,
    32'sd15, 32'sd49, 32'sd91, 32'sd561, 32'sd1105, 32'sd1729, 32'sd8911,
    32'sd46657, 32'sd62745, 32'sd294409, 32'sh4000_0000, 32'sd2147483646,
    32'sd1299963601, 32'sd2465, 32'sh7FFF_FFFF
  };

  localparam int unsigned CARMICHAEL_VALUES [20] = '{
    561, 1105, 1729, 2465, 2821, 6601, 8911, 10585, 15841, 29341,
    41041, 46657, 52633, 62745, 63973, 75361, 294409, 512461, 101101, 56052361
  };

  localparam int unsigned SMALL_PRIMES [30] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
    53, 59, 61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113
  };

  logic clk = 1'b0;
  logic rst;
  int src_idle_pct;
  int dst_idle_pct;
  int unsigned cycle_count = 0;
  flag_scoreboard sb;

  cmt_in_if  item_if();
  cmt_out_if result_if();

  carmichael_number_test_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  // Clock: period 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    result_if.ready <= (dst_idle_pct == 0) || ($urandom_range(99) >= dst_idle_pct);
  end

  // Record accepted input words and check returned flags
  always @(posedge clk) begin
    if (!rst && item_if.valid && item_if.ready) sb.note_value(item_if.value);
    if (!rst && result_if.valid && result_if.ready) sb.check_flag(result_if.flag);
  end

  // Offer one word, idling first at random; returns at the falling edge after acceptance
  task automatic send_value(input logic signed [31:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.value <= value;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the input idle until every expected flag has come back
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    while (sb.flag_q.size() != 0) @(negedge clk);
  endtask

  // Pick a random word: mostly well-formed composites, with noise around them
  function automatic logic signed [31:0] random_value();
    int pick;
    int unsigned prod;
    int unsigned k;
    int unsigned count;
    pick = $urandom_range(99);
    if (pick < 12) return {1'b1, 31'($urandom)};
    if (pick < 17) return $urandom_range(0, 3);
    if (pick < 37) return $urandom_range(2, 4095);
    if (pick < 55) return CARMICHAEL_VALUES[$urandom_range(19)];
    if (pick < 65) begin
      // Chernick form (6k+1)(12k+1)(18k+1)
      k = $urandom_range(1, 20);
      return (6 * k + 1) * (12 * k + 1) * (18 * k + 1);
    end
    if (pick < 80) begin
      // Product of a few small primes, repeats allowed
      prod = 1;
      count = $urandom_range(2, 4);
      for (int n = 0; n < count; n++) prod = prod * SMALL_PRIMES[$urandom_range(29)];
      return prod;
    end
    if (pick < 90) return {1'b0, 29'($urandom), 2'b00};
    return 9 * ($urandom_range(0, 238609293) | 1);
  endfunction

  initial begin
    sb = new();
    src_idle_pct = 21;
    dst_idle_pct = 60;
    rst = 1'b1;
    item_if.valid = 1'b0;
    item_if.value = '0;

    // Hold reset, then release it at a falling edge
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words, then a full drain
    foreach (DIRECTED_VALUES[n]) send_value(DIRECTED_VALUES[n]);
    wait_drained();

    // Random words over three idling phases
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        src_idle_pct = 60;
        dst_idle_pct = 21;
      end else if (n == 2 * RANDOM_WORDS / 3) begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      send_value(random_value());
    end
    wait_drained();

    // Let any stray word show up before judging
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.flag_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
